FILE: rtl/elrl_pkg.sv
// Shared types and constants for the escalating lockout rate limiter.
package elrl_pkg;

    localparam int unsigned TimeW    = 32;
    localparam int unsigned FailW    = 16;
    localparam int unsigned RetryW   = 22;
    localparam int unsigned NumCool  = 6;
    localparam int unsigned CoolIdxW = 3;
    localparam int unsigned AddrW    = 5;

    localparam logic [FailW-1:0] FailMax = 16'hFFFF;

    localparam logic [TimeW-1:0] MsRoundUp = 32'd999;
    localparam logic [28:0]      SecRecip  = 29'd274877907;
    localparam int unsigned      SecShift  = 38;
    localparam int unsigned      ProdW     = TimeW + 29;

    localparam logic [TimeW-1:0] IdleResetDefault = 32'd3600000;
    localparam logic [TimeW-1:0] CoolDefault [NumCool] = '{
        32'd0, 32'd0, 32'd10000, 32'd60000, 32'd300000, 32'd1800000
    };

    typedef enum logic [1:0] {
        FUNC_CHECK   = 2'd0,
        FUNC_SUCCESS = 2'd1,
        FUNC_FAILURE = 2'd2
    } t_func;

    typedef enum logic [2:0] {
        REG_IDLE_RESET = 3'd0,
        REG_COOL_1     = 3'd1,
        REG_COOL_2     = 3'd2,
        REG_COOL_3     = 3'd3,
        REG_COOL_4     = 3'd4,
        REG_COOL_5     = 3'd5,
        REG_COOL_CAP   = 3'd6
    } t_reg_idx;

    typedef struct packed {
        logic [TimeW-1:0]               idle_reset_ms;
        logic [NumCool-1:0][TimeW-1:0]  cooldown;
    } t_cfg;

    typedef struct packed {
        logic             verdict;
        logic [TimeW-1:0] wait_ms;
        logic [FailW-1:0] failures;
    } t_mid;

endpackage

FILE: rtl/escalating_lockout_rate_limiter_unit.sv
// Top level of the escalating lockout rate limiter.
// Takes one request (a check, success or failure event with its millisecond
// time) per clock and returns one result per request, in order. The request is
// captured in an input register, the state update writes a middle register, and
// the seconds conversion multiplier writes the output register, which drives
// m_axis_tvalid. The lockout state is updated as a request moves from the input
// register to the middle register, so a new request is accepted every cycle
// while the output side keeps taking results.
// Configuration registers sit on the APB port at byte address 4*index and
// should be written only while no request is in flight.
module escalating_lockout_rate_limiter_unit (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       s_axis_tvalid,
    output logic                       s_axis_tready,
    input  logic [31:0]                s_axis_tdata,  // [31:0] now_ms
    input  logic [1:0]                 s_axis_tuser,  // [1:0] func
    output logic                       m_axis_tvalid,
    input  logic                       m_axis_tready,
    output logic [39:0]                m_axis_tdata,  // [0] verdict, [22:1] retry_after_s,
                                                      // [38:23] failures, [39] zero
    input  logic                       psel,
    input  logic                       penable,
    input  logic                       pwrite,
    input  logic [elrl_pkg::AddrW-1:0] paddr,
    input  logic [31:0]                pwdata,
    output logic [31:0]                prdata,
    output logic                       pready
);
    import elrl_pkg::*;

    t_cfg              cfg;
    t_mid              mid;
    logic              mid_valid;
    logic              mid_ready;
    logic              verdict;
    logic [RetryW-1:0] retry_after_s;
    logic [FailW-1:0]  failures;

    elrl_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    elrl_core u_core (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cfg    (cfg),
        .i_valid  (s_axis_tvalid),
        .o_ready  (s_axis_tready),
        .i_func   (s_axis_tuser),
        .i_now_ms (s_axis_tdata),
        .o_valid  (mid_valid),
        .i_ready  (mid_ready),
        .o_mid    (mid)
    );

    elrl_sec_div u_div (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_valid         (mid_valid),
        .o_ready         (mid_ready),
        .i_mid           (mid),
        .o_valid         (m_axis_tvalid),
        .i_ready         (m_axis_tready),
        .o_verdict       (verdict),
        .o_retry_after_s (retry_after_s),
        .o_failures      (failures)
    );

    assign m_axis_tdata = {1'b0, failures, retry_after_s, verdict};

endmodule

FILE: rtl/elrl_cfg.sv
// APB register file holding the idle threshold and the cooldown table.
module elrl_cfg (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      psel,
    input  logic                      penable,
    input  logic                      pwrite,
    input  logic [elrl_pkg::AddrW-1:0] paddr,
    input  logic [31:0]               pwdata,
    output logic [31:0]               prdata,
    output logic                      pready,
    output elrl_pkg::t_cfg            o_cfg
);
    import elrl_pkg::*;

    t_cfg       r_cfg;
    t_reg_idx   idx;
    logic       wr_en;

    assign pready = 1'b1;
    assign idx    = t_reg_idx'(paddr[AddrW-1:2]);
    assign wr_en  = psel && penable && pwrite && pready;
    assign o_cfg  = r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.idle_reset_ms <= IdleResetDefault;
            for (int i = 0; i < NumCool; i++) begin
                r_cfg.cooldown[i] <= CoolDefault[i];
            end
        end else if (wr_en) begin
            unique case (idx)
                REG_IDLE_RESET: r_cfg.idle_reset_ms <= pwdata;
                REG_COOL_1:     r_cfg.cooldown[0]   <= pwdata;
                REG_COOL_2:     r_cfg.cooldown[1]   <= pwdata;
                REG_COOL_3:     r_cfg.cooldown[2]   <= pwdata;
                REG_COOL_4:     r_cfg.cooldown[3]   <= pwdata;
                REG_COOL_5:     r_cfg.cooldown[4]   <= pwdata;
                REG_COOL_CAP:   r_cfg.cooldown[5]   <= pwdata;
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (idx)
            REG_IDLE_RESET: prdata = r_cfg.idle_reset_ms;
            REG_COOL_1:     prdata = r_cfg.cooldown[0];
            REG_COOL_2:     prdata = r_cfg.cooldown[1];
            REG_COOL_3:     prdata = r_cfg.cooldown[2];
            REG_COOL_4:     prdata = r_cfg.cooldown[3];
            REG_COOL_5:     prdata = r_cfg.cooldown[4];
            REG_COOL_CAP:   prdata = r_cfg.cooldown[5];
            default:        prdata = '0;
        endcase
    end

endmodule

FILE: rtl/elrl_core.sv
// Input register, lockout state and per-event update into the middle register.
module elrl_core (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  elrl_pkg::t_cfg             i_cfg,
    input  logic                       i_valid,
    output logic                       o_ready,
    input  logic [1:0]                 i_func,
    input  logic [elrl_pkg::TimeW-1:0] i_now_ms,
    output logic                       o_valid,
    input  logic                       i_ready,
    output elrl_pkg::t_mid             o_mid
);
    import elrl_pkg::*;

    logic              r_in_v;
    t_func             r_func;
    logic [TimeW-1:0]  r_now;

    logic [FailW-1:0]  r_total, n_total;
    logic [TimeW-1:0]  r_end, n_end;
    logic [TimeW-1:0]  r_lft, n_lft;

    logic              r_mid_v;
    t_mid              r_mid;

    logic              mid_ready;
    logic              step;
    logic              verdict;
    logic [FailW-1:0]  inc;
    logic [CoolIdxW-1:0] cool_idx;
    logic [TimeW-1:0]  cd;
    logic [TimeW-1:0]  arm_sum;
    logic [TimeW-1:0]  d_old;
    logic [TimeW-1:0]  d_new;
    logic              run_old;
    logic              run_new;
    logic              idle_hit;

    assign mid_ready = !r_mid_v || i_ready;
    assign o_ready   = !r_in_v || mid_ready;
    assign step      = r_in_v && mid_ready;
    assign o_valid   = r_mid_v;
    assign o_mid     = r_mid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_v <= 1'b0;
        end else if (o_ready) begin
            r_in_v <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_func <= t_func'(i_func);
            r_now  <= i_now_ms;
        end
    end

    assign inc      = (r_total == FailMax) ? r_total : r_total + 1'b1;
    assign cool_idx = (inc > FailW'(NumCool)) ? CoolIdxW'(NumCool - 1)
                                              : CoolIdxW'(inc - 1'b1);
    assign cd       = i_cfg.cooldown[cool_idx];
    assign arm_sum  = r_now + cd;
    assign d_old    = r_end - r_now;
    assign run_old  = (r_end != '0) && (d_old != '0) && !d_old[TimeW-1];
    assign idle_hit = (r_end == '0) && (r_lft != '0)
                      && ((r_now - r_lft) >= i_cfg.idle_reset_ms);

    always_comb begin
        n_total = r_total;
        n_end   = r_end;
        n_lft   = r_lft;
        verdict = 1'b0;
        case (r_func)
            FUNC_CHECK: begin
                if (idle_hit) begin
                    n_total = '0;
                end
                if (r_end != '0) begin
                    if (run_old) begin
                        verdict = 1'b1;
                    end else begin
                        n_end = '0;
                    end
                end
            end
            FUNC_SUCCESS: begin
                n_total = '0;
                n_end   = '0;
            end
            FUNC_FAILURE: begin
                n_lft   = r_now;
                n_total = inc;
                if (cd != '0) begin
                    n_end = (arm_sum == '0) ? TimeW'(1) : arm_sum;
                end
            end
            default: ;
        endcase
    end

    assign d_new   = n_end - r_now;
    assign run_new = (n_end != '0) && (d_new != '0) && !d_new[TimeW-1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_total <= '0;
            r_end   <= '0;
            r_lft   <= '0;
            r_mid_v <= 1'b0;
        end else begin
            if (step) begin
                r_total <= n_total;
                r_end   <= n_end;
                r_lft   <= n_lft;
            end
            if (mid_ready) begin
                r_mid_v <= r_in_v;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (step) begin
            r_mid.verdict  <= verdict;
            r_mid.wait_ms  <= run_new ? d_new + MsRoundUp : '0;
            r_mid.failures <= n_total;
        end
    end

endmodule

FILE: rtl/elrl_sec_div.sv
// Millisecond-to-second conversion by reciprocal multiply into the result register.
module elrl_sec_div (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_valid,
    output logic                         o_ready,
    input  elrl_pkg::t_mid               i_mid,
    output logic                         o_valid,
    input  logic                         i_ready,
    output logic                         o_verdict,
    output logic [elrl_pkg::RetryW-1:0]  o_retry_after_s,
    output logic [elrl_pkg::FailW-1:0]   o_failures
);
    import elrl_pkg::*;

    logic              r_valid;
    logic              r_verdict;
    logic [RetryW-1:0] r_retry;
    logic [FailW-1:0]  r_failures;
    logic [ProdW-1:0]  prod;

    assign o_ready = !r_valid || i_ready;
    assign prod    = ProdW'(i_mid.wait_ms) * ProdW'(SecRecip);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_verdict  <= i_mid.verdict;
            r_retry    <= prod[SecShift +: RetryW];
            r_failures <= i_mid.failures;
        end
    end

    assign o_valid         = r_valid;
    assign o_verdict       = r_verdict;
    assign o_retry_after_s = r_retry;
    assign o_failures      = r_failures;

endmodule
